>>> hdl/ghi_pkg.sv
// Package for the gyro heading integrator: field widths, fixed-point constants and word types.
package ghi_pkg;

    // Calibration length and sensor scaling
    localparam int unsigned CAL_SAMPLES   = 200;
    localparam int unsigned LSB_PER_DEG   = 131;
    localparam int unsigned TICKS_PER_SEC = 1000000;

    // Field widths
    localparam int unsigned RATE_W    = 16;
    localparam int unsigned DT_W      = 16;
    localparam int unsigned HEAD_W    = 44;
    localparam int unsigned COUNT_W   = 8;
    localparam int unsigned BIAS_W    = 24;
    localparam int unsigned CRATE_W   = BIAS_W + 1;
    localparam int unsigned PROD_W    = CRATE_W + DT_W + 1;
    localparam int unsigned SUM_W     = HEAD_W + 1;
    localparam int unsigned IN_DATA_W  = 32;
    localparam int unsigned OUT_DATA_W = 48;

    // Half and full circle in heading units (LSB-microseconds per calibration sample)
    localparam longint HALF_UNITS   = 64'(180) * 64'(LSB_PER_DEG) * 64'(TICKS_PER_SEC)
                                      * 64'(CAL_SAMPLES);
    localparam longint CIRCLE_UNITS = 2 * HALF_UNITS;

    localparam logic signed [SUM_W-1:0]   HALF_S   = SUM_W'(HALF_UNITS);
    localparam logic signed [SUM_W-1:0]   NHALF_S  = SUM_W'(-HALF_UNITS);
    localparam logic signed [SUM_W-1:0]   CIRCLE_S = SUM_W'(CIRCLE_UNITS);
    localparam logic signed [HEAD_W-1:0]  HEAD_HALF  = HEAD_W'(HALF_UNITS);
    localparam logic signed [HEAD_W-1:0]  HEAD_NHALF = HEAD_W'(-HALF_UNITS);
    localparam logic signed [CRATE_W-1:0] CAL_MUL  = CRATE_W'(CAL_SAMPLES);
    localparam logic [COUNT_W-1:0]        CAL_LAST = COUNT_W'(CAL_SAMPLES);

    typedef logic signed [HEAD_W-1:0]  t_heading;
    typedef logic signed [CRATE_W-1:0] t_crate;
    typedef logic signed [PROD_W-1:0]  t_prod;

endpackage

>>> hdl/gyro_heading_integrator.sv
// Top level: gyro yaw-rate integrator with start-up bias calibration.
//
//  channel  | dir | tdata (low bit up)                  | tuser
//  ---------+-----+-------------------------------------+-------------
//  s_axis   | in  | raw_rate[15:0], elapsed_us[31:16]   | -
//  m_axis   | out | heading[43:0], zero pad [47:44]     | calibrating
//
//  One word per cycle is taken and returned while m_axis_tready stays high; a
//  word passes input register, scaled-rate stage and product stage, then the
//  accumulate-and-wrap step that loads the output register behind m_axis_tvalid.
//  The heading accumulator loop (add, compare with half a circle, one wrap)
//  is the recurrence that sets the single-cycle rate.
//  Reset clears calibration count, bias sum, heading and all valid flags.
//  A stalled output holds its word; earlier stages keep filling bubbles.
module gyro_heading_integrator
    import ghi_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // raw_rate[15:0], elapsed_us[31:16]
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,   // heading[43:0], zero [47:44]
    output logic                  m_axis_tuser    // calibrating
);

    // Stage valid flags and handshake
    logic r1_valid, r2_valid, r3_valid, r_o_valid;
    logic free1, free2, free3, out_load;

    // Input register
    logic signed [RATE_W-1:0] r1_raw;
    logic [DT_W-1:0]          r1_dt;

    // Calibration state
    logic [COUNT_W-1:0]       r_cal_count;
    logic signed [BIAS_W-1:0] r_bias_sum;
    logic                     cal_now;

    // Scaled-rate stage
    t_crate          r2_rate;
    logic [DT_W-1:0] r2_dt;
    logic            r2_cal;
    t_crate          n_rate;

    // Product stage
    t_prod r3_prod;
    logic  r3_cal;
    t_prod n_prod;

    // Accumulator and output
    t_heading                r_heading_acc;
    logic                    r_o_cal;
    logic signed [SUM_W-1:0] acc_sum;
    t_heading                n_heading_acc;

    // Each stage loads when empty or when the stage after it moves on
    assign out_load      = !r_o_valid || m_axis_tready;
    assign free3         = !r3_valid || out_load;
    assign free2         = !r2_valid || free3;
    assign free1         = !r1_valid || free2;
    assign s_axis_tready = free1;

    // Scale the sample and remove the bias
    assign cal_now = r_cal_count < CAL_LAST;
    assign n_rate  = CRATE_W'(r1_raw) * CAL_MUL - CRATE_W'(r_bias_sum);

    // Rate times elapsed microseconds
    assign n_prod = PROD_W'(r2_rate) * PROD_W'($signed({1'b0, r2_dt}));

    // Accumulate and wrap once into (-half, +half]
    assign acc_sum = SUM_W'(r_heading_acc) + SUM_W'(r3_prod);
    always_comb begin
        priority if (acc_sum > HALF_S) begin
            n_heading_acc = HEAD_W'(acc_sum - CIRCLE_S);
        end else if (acc_sum <= NHALF_S) begin
            n_heading_acc = HEAD_W'(acc_sum + CIRCLE_S);
        end else begin
            n_heading_acc = HEAD_W'(acc_sum);
        end
    end

    // Control state and valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid      <= 1'b0;
            r2_valid      <= 1'b0;
            r3_valid      <= 1'b0;
            r_o_valid     <= 1'b0;
            r_cal_count   <= '0;
            r_bias_sum    <= '0;
            r_heading_acc <= '0;
        end else begin
            if (free1) begin
                r1_valid <= s_axis_tvalid;
            end
            if (free2) begin
                r2_valid <= r1_valid;
                if (r1_valid && cal_now) begin
                    r_cal_count <= r_cal_count + COUNT_W'(1);
                    r_bias_sum  <= r_bias_sum + BIAS_W'(r1_raw);
                end
            end
            if (free3) begin
                r3_valid <= r2_valid;
            end
            if (out_load) begin
                r_o_valid <= r3_valid;
                if (r3_valid && !r3_cal) begin
                    r_heading_acc <= n_heading_acc;
                end
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (free1 && s_axis_tvalid) begin
            r1_raw <= s_axis_tdata[RATE_W-1:0];
            r1_dt  <= s_axis_tdata[RATE_W+DT_W-1:RATE_W];
        end
        if (free2 && r1_valid) begin
            r2_rate <= n_rate;
            r2_dt   <= r1_dt;
            r2_cal  <= cal_now;
        end
        if (free3 && r2_valid) begin
            r3_prod <= n_prod;
            r3_cal  <= r2_cal;
        end
        if (out_load && r3_valid) begin
            r_o_cal <= r3_cal;
        end
    end

    // Drive the result word
    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tdata  = OUT_DATA_W'(unsigned'(r_heading_acc));
    assign m_axis_tuser  = r_o_cal;

endmodule

>>> hdl/ghi_checker.sv
// Port checker for the gyro heading integrator, bound to the top level.
module ghi_checker
    import ghi_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [OUT_DATA_W-1:0] m_axis_tdata,
    input logic                  m_axis_tuser
);

    t_heading head;
    assign head = t_heading'(m_axis_tdata[HEAD_W-1:0]);

    // A calibration word carries a zero heading
    a_cal_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> head == '0)
        else $error("calibration word with non-zero heading");

    // Heading stays inside (-half, +half]
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (head > HEAD_NHALF) && (head <= HEAD_HALF))
        else $error("heading outside half circle");

    // Stalled word stays offered
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("output word dropped while stalled");

    // Stalled word keeps its content
    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("output word changed while stalled");

endmodule

bind gyro_heading_integrator ghi_checker u_ghi_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
